[hdl/mlfq_pkg.sv]
package mlfq_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ID_W   = 8;
  localparam int TICK_W = 16;
  localparam int TIME_W = 24;
  localparam int LVL_W  = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 1'b1;

  localparam logic [TICK_W-1:0] QUANTUM1_RST = 16'd10;
  localparam logic [TICK_W-1:0] QUANTUM2_RST = 16'd30;

  localparam logic [LVL_W-1:0] LVL_RR1  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_RR2  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_FCFS = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] arr;
    logic [TICK_W-1:0] burst;
  } entry_t;

  // queued process for the lower levels, with its remaining burst
  typedef struct packed {
    entry_t            ent;
    logic [TICK_W-1:0] rem;
  } item_t;

  typedef struct packed {
    logic load;
    logic sort_rd;
    logic sort_hold;
    logic sort_cmp;
    logic sort_wb;
    logic l1_start;
    logic time_init;
    logic l1_step;
    logic l2_start;
    logic l2_step;
    logic l3_start;
    logic l3_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic n_empty;
    logic i_more;
    logic j_more;
    logic k_more2;
    logic k_more3;
    logic l2_empty;
    logic l3_empty;
    logic fits1;
    logic fits2;
    logic prod_ok;
    logic out_free;
  } status_t;

endpackage

[hdl/mlfq_stream_if.sv]
interface mlfq_in_if;
  logic                                valid;
  logic                                ready;
  logic [mlfq_pkg::ID_W-1:0]           proc_id;
  logic [mlfq_pkg::TICK_W-1:0]         arrival_time;
  logic [mlfq_pkg::TICK_W-1:0]         burst_time;
  logic                                batch_last;

  modport source (output valid, proc_id, arrival_time, burst_time, batch_last, input ready);
  modport sink   (input valid, proc_id, arrival_time, burst_time, batch_last, output ready);
endinterface

interface mlfq_out_if;
  logic                                valid;
  logic                                ready;
  logic [mlfq_pkg::ID_W-1:0]           out_proc_id;
  logic [mlfq_pkg::LVL_W-1:0]          finish_level;
  logic [mlfq_pkg::TICK_W-1:0]         level_burst;
  logic signed [mlfq_pkg::TIME_W-1:0]  waiting_time;
  logic signed [mlfq_pkg::TIME_W-1:0]  turnaround_time;
  logic                                result_last;

  modport source (output valid, out_proc_id, finish_level, level_burst, waiting_time,
                  turnaround_time, result_last, input ready);
  modport sink   (input valid, out_proc_id, finish_level, level_burst, waiting_time,
                  turnaround_time, result_last, output ready);
endinterface

[hdl/mlfq_batch_schedule_metrics_unit.sv]
// channel   dir  handshake       payload
// in_i      in   valid / ready   proc_id, arrival_time, burst_time, batch_last
// out_o     out  valid / ready   out_proc_id, finish_level, level_burst,
//                                waiting_time, turnaround_time, result_last
// cfg       in   cfg_we_i        cfg_idx_i (0 quantum_level1, 1 quantum_level2), cfg_data_i
//
// loading accepts one transaction per cycle; the last one starts the batch of n entries:
// sort through the process table (one read, one write port), then one process per cycle
// in each level it visits while no completion waits for output room, plus overhead states
// (read and clock init before level one, a read before each lower level, a flush of the last
// result to the output register). input is taken only while loading; a stalled output holds
// completions and the flush. async reset needs no clearing pass; quanta reset to 10 and 30.
module mlfq_batch_schedule_metrics_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mlfq_in_if.sink                         in_i,
  mlfq_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mlfq_pkg::cmd_t    cmd;
  mlfq_pkg::status_t status;
  logic              in_ready;

  assign in_i.ready = in_ready;

  mlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.batch_last),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  mlfq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .proc_id_i         (in_i.proc_id),
    .arrival_time_i    (in_i.arrival_time),
    .burst_time_i      (in_i.burst_time),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_proc_id_o     (out_o.out_proc_id),
    .finish_level_o    (out_o.finish_level),
    .level_burst_o     (out_o.level_burst),
    .waiting_time_o    (out_o.waiting_time),
    .turnaround_time_o (out_o.turnaround_time),
    .result_last_o     (out_o.result_last),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

[hdl/mlfq_ctrl.sv]
module mlfq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  mlfq_pkg::status_t status_i,
  output mlfq_pkg::cmd_t    cmd_o,
  output logic              in_ready_o
);

  typedef enum logic [12:0] {
    S_LOAD     = 13'b0000000000001,
    S_SRT_RD   = 13'b0000000000010,
    S_SRT_HOLD = 13'b0000000000100,
    S_SRT_CMP  = 13'b0000000001000,
    S_SRT_WB   = 13'b0000000010000,
    S_L1_RD    = 13'b0000000100000,
    S_T0       = 13'b0000001000000,
    S_L1_EX    = 13'b0000010000000,
    S_L2_RD    = 13'b0000100000000,
    S_L2_EX    = 13'b0001000000000,
    S_L3_RD    = 13'b0010000000000,
    S_L3_EX    = 13'b0100000000000,
    S_FLUSH    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = S_SRT_RD;
        end
      end
      S_SRT_RD: begin
        if (status_i.n_empty) begin
          state_d = S_LOAD;
        end else if (!status_i.i_more) begin
          state_d = S_L1_RD;
        end else begin
          cmd_o.sort_rd = 1'b1;
          state_d       = S_SRT_HOLD;
        end
      end
      S_SRT_HOLD: begin
        cmd_o.sort_hold = 1'b1;
        state_d         = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd_o.sort_cmp = 1'b1;
        if (!status_i.j_more) state_d = S_SRT_WB;
      end
      S_SRT_WB: begin
        cmd_o.sort_wb = 1'b1;
        state_d       = S_SRT_RD;
      end
      S_L1_RD: begin
        cmd_o.l1_start = 1'b1;
        state_d        = S_T0;
      end
      S_T0: begin
        cmd_o.time_init = 1'b1;
        state_d         = S_L1_EX;
      end
      S_L1_EX: begin
        // a completion waits until the result buffer has room
        if (!status_i.fits1 || status_i.prod_ok) begin
          cmd_o.l1_step = 1'b1;
          if (!status_i.i_more) state_d = S_L2_RD;
        end
      end
      S_L2_RD: begin
        if (status_i.l2_empty) begin
          state_d = S_L3_RD;
        end else begin
          cmd_o.l2_start = 1'b1;
          state_d        = S_L2_EX;
        end
      end
      S_L2_EX: begin
        if (!status_i.fits2 || status_i.prod_ok) begin
          cmd_o.l2_step = 1'b1;
          if (!status_i.k_more2) state_d = S_L3_RD;
        end
      end
      S_L3_RD: begin
        if (status_i.l3_empty) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.l3_start = 1'b1;
          state_d        = S_L3_EX;
        end
      end
      S_L3_EX: begin
        if (status_i.prod_ok) begin
          cmd_o.l3_step = 1'b1;
          if (!status_i.k_more3) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

[hdl/mlfq_dp.sv]
module mlfq_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [mlfq_pkg::ID_W-1:0]            proc_id_i,
  input  logic [mlfq_pkg::TICK_W-1:0]          arrival_time_i,
  input  logic [mlfq_pkg::TICK_W-1:0]          burst_time_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [mlfq_pkg::ID_W-1:0]            out_proc_id_o,
  output logic [mlfq_pkg::LVL_W-1:0]           finish_level_o,
  output logic [mlfq_pkg::TICK_W-1:0]          level_burst_o,
  output logic signed [mlfq_pkg::TIME_W-1:0]   waiting_time_o,
  output logic signed [mlfq_pkg::TIME_W-1:0]   turnaround_time_o,
  output logic                                 result_last_o,
  input  mlfq_pkg::cmd_t                       cmd_i,
  output mlfq_pkg::status_t                    status_o
);

  localparam int IDX_W  = mlfq_pkg::IDX_W;
  localparam int CNT_W  = mlfq_pkg::CNT_W;
  localparam int TICK_W = mlfq_pkg::TICK_W;
  localparam int TIME_W = mlfq_pkg::TIME_W;
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(mlfq_pkg::MAX_PROCS);
  localparam logic [TIME_W-TICK_W-1:0] ZEXT = '0;

  // configuration
  logic [TICK_W-1:0] q1_q, q2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q <= mlfq_pkg::QUANTUM1_RST;
      q2_q <= mlfq_pkg::QUANTUM2_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlfq_pkg::CFG_QUANTUM1: q1_q <= cfg_data_i;
        mlfq_pkg::CFG_QUANTUM2: q2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counters and clock
  logic [CNT_W-1:0]  n_q, i_q, j_q, k_q, c2_q, c3_q;
  logic [TIME_W-1:0] t_q;

  // memories and read registers
  mlfq_pkg::entry_t pt_mem [mlfq_pkg::MAX_PROCS];
  mlfq_pkg::item_t  l2_mem [mlfq_pkg::MAX_PROCS];
  mlfq_pkg::item_t  l3_mem [mlfq_pkg::MAX_PROCS];
  mlfq_pkg::entry_t pt_rd_q, hold_q;
  mlfq_pkg::item_t  l2_rd_q, l3_rd_q;

  logic             pt_we, pt_re, l2_re, l3_re;
  logic [IDX_W-1:0] pt_waddr, pt_raddr, l2_raddr, l3_raddr;
  mlfq_pkg::entry_t pt_wdata;

  logic full, swap, fits1, fits2;
  assign full  = (n_q == FULL);
  assign swap  = (hold_q.arr > pt_rd_q.arr);
  assign fits1 = (pt_rd_q.burst <= q1_q);
  assign fits2 = (l2_rd_q.rem <= q2_q);

  // current process of the level walk
  mlfq_pkg::entry_t          cur_ent;
  logic [TICK_W-1:0]         cur_r, cur_q, add;
  logic [mlfq_pkg::LVL_W-1:0] cur_lvl;
  logic                      cur_fits, step, prod, push2, push3;
  logic [TIME_W-1:0]         t_next;
  mlfq_pkg::item_t           push_item;

  always_comb begin
    if (cmd_i.l3_step) begin
      cur_ent  = l3_rd_q.ent;
      cur_r    = l3_rd_q.rem;
      cur_q    = '0;
      cur_lvl  = mlfq_pkg::LVL_FCFS;
      cur_fits = 1'b1;
    end else if (cmd_i.l2_step) begin
      cur_ent  = l2_rd_q.ent;
      cur_r    = l2_rd_q.rem;
      cur_q    = q2_q;
      cur_lvl  = mlfq_pkg::LVL_RR2;
      cur_fits = fits2;
    end else begin
      cur_ent  = pt_rd_q;
      cur_r    = pt_rd_q.burst;
      cur_q    = q1_q;
      cur_lvl  = mlfq_pkg::LVL_RR1;
      cur_fits = fits1;
    end
  end

  assign step          = cmd_i.l1_step | cmd_i.l2_step | cmd_i.l3_step;
  assign prod          = step & cur_fits;
  assign push2         = cmd_i.l1_step & ~fits1;
  assign push3         = cmd_i.l2_step & ~fits2;
  assign add           = cur_fits ? cur_r : cur_q;
  assign t_next        = t_q + {ZEXT, add};
  assign push_item.ent = cur_ent;
  assign push_item.rem = cur_r - cur_q;

  // process table ports
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = n_q[IDX_W-1:0];
    pt_wdata = hold_q;
    if (cmd_i.load && !full) begin
      pt_we          = 1'b1;
      pt_wdata.id    = proc_id_i;
      pt_wdata.arr   = arrival_time_i;
      pt_wdata.burst = burst_time_i;
    end else if (cmd_i.sort_cmp && swap) begin
      pt_we    = 1'b1;
      pt_waddr = j_q[IDX_W-1:0];
    end else if (cmd_i.sort_wb) begin
      pt_we    = 1'b1;
      pt_waddr = i_q[IDX_W-1:0];
    end
  end

  always_comb begin
    pt_re    = cmd_i.sort_rd | cmd_i.sort_hold | cmd_i.sort_cmp | cmd_i.l1_start |
               cmd_i.l1_step;
    pt_raddr = '0;
    if (cmd_i.sort_rd) begin
      pt_raddr = i_q[IDX_W-1:0];
    end else if (cmd_i.sort_hold) begin
      pt_raddr = j_q[IDX_W-1:0];
    end else if (cmd_i.sort_cmp) begin
      pt_raddr = j_q[IDX_W-1:0] + IDX_W'(1);
    end else if (cmd_i.l1_step) begin
      pt_raddr = i_q[IDX_W-1:0] + IDX_W'(1);
    end
  end

  assign l2_re    = cmd_i.l2_start | cmd_i.l2_step;
  assign l3_re    = cmd_i.l3_start | cmd_i.l3_step;
  assign l2_raddr = cmd_i.l2_step ? k_q[IDX_W-1:0] + IDX_W'(1) : '0;
  assign l3_raddr = cmd_i.l3_step ? k_q[IDX_W-1:0] + IDX_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rd_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (push2) l2_mem[c2_q[IDX_W-1:0]] <= push_item;
    if (l2_re) l2_rd_q <= l2_mem[l2_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (push3) l3_mem[c3_q[IDX_W-1:0]] <= push_item;
    if (l3_re) l3_rd_q <= l3_mem[l3_raddr];
  end

  // entry i of the exchange sort lives in hold_q while j sweeps
  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_hold || (cmd_i.sort_cmp && swap)) hold_q <= pt_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= '0;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      c2_q <= '0;
      c3_q <= '0;
      t_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        i_q <= '0;
        if (!full) n_q <= n_q + ONE;
      end
      if (cmd_i.flush) n_q <= '0;
      if (cmd_i.sort_rd) j_q <= i_q + ONE;
      if (cmd_i.sort_cmp) j_q <= j_q + ONE;
      if (cmd_i.sort_wb || cmd_i.l1_step) i_q <= i_q + ONE;
      if (cmd_i.l1_start) begin
        i_q  <= '0;
        c2_q <= '0;
        c3_q <= '0;
      end
      if (push2) c2_q <= c2_q + ONE;
      if (push3) c3_q <= c3_q + ONE;
      if (cmd_i.l2_start || cmd_i.l3_start) k_q <= '0;
      if (cmd_i.l2_step || cmd_i.l3_step) k_q <= k_q + ONE;
      if (cmd_i.time_init) t_q <= {ZEXT, pt_rd_q.arr};
      if (step) t_q <= t_next;
    end
  end

  // one result is held back so the last of the batch can be marked
  logic                       pend_v_q, out_v_q, out_free, move;
  mlfq_pkg::entry_t           pend_ent_q;
  logic [mlfq_pkg::LVL_W-1:0] pend_lvl_q;
  logic [TICK_W-1:0]          pend_lb_q;
  logic [TIME_W-1:0]          pend_t_q, tat, wt;

  assign out_free = ~out_v_q | out_ready_i;
  assign move     = pend_v_q & (prod | cmd_i.flush);
  assign tat      = pend_t_q - {ZEXT, pend_ent_q.arr};
  assign wt       = tat - {ZEXT, pend_ent_q.burst};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod) begin
      pend_ent_q <= cur_ent;
      pend_lvl_q <= cur_lvl;
      pend_lb_q  <= cur_r;
      pend_t_q   <= t_next;
    end
    if (move) begin
      out_proc_id_o     <= pend_ent_q.id;
      finish_level_o    <= pend_lvl_q;
      level_burst_o     <= pend_lb_q;
      waiting_time_o    <= wt;
      turnaround_time_o <= tat;
      result_last_o     <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_v_q;

  assign status_o.n_empty  = (n_q == '0);
  assign status_o.i_more   = ((i_q + ONE) < n_q);
  assign status_o.j_more   = ((j_q + ONE) < n_q);
  assign status_o.k_more2  = ((k_q + ONE) < c2_q);
  assign status_o.k_more3  = ((k_q + ONE) < c3_q);
  assign status_o.l2_empty = (c2_q == '0);
  assign status_o.l3_empty = (c3_q == '0);
  assign status_o.fits1    = fits1;
  assign status_o.fits2    = fits2;
  assign status_o.prod_ok  = ~pend_v_q | out_free;
  assign status_o.out_free = out_free;

endmodule
